>>> sv/dcf_pkg.sv
`default_nettype none
package dcf_pkg;

  // Channel store geometry
  localparam int MAX_CHANNELS = 64;
  localparam int CH_W         = 6;
  localparam int CFG_W        = 7;
  localparam int LEVEL_IN_W   = 8;
  localparam int SECS_W       = 8;

  // Fixed-point formats: level Q8.16 unsigned, step Q9.16 signed
  localparam int FRAC_W   = 16;
  localparam int LEVEL_W  = 24;
  localparam int STEP_W   = 25;
  localparam int SUM_W    = 26;
  localparam int MEM_W    = LEVEL_W + STEP_W;

  // Divider operands: dividend is the level difference in Q8.16,
  // divisor is seconds times ticks per second
  localparam int QUOT_W   = 24;
  localparam int DIVR_W   = 15;
  localparam int DCNT_W   = 5;

  localparam int unsigned TICKS_PER_SEC   = 100;
  localparam logic [CFG_W-1:0] CFG_RESET  = 7'd60;
  localparam logic [CFG_W-1:0] CFG_MAX    = 7'(MAX_CHANNELS);
  localparam logic [STEP_W-1:0] LEVEL_MAX_Q = 25'h0FF0000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_LOAD_WR,
    ST_TICK_RD,
    ST_TICK_WB
  } dcf_state_t;

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_TICK = 1'b1
  } dcf_func_t;

  typedef struct packed {
    logic                  func;
    logic [CH_W-1:0]       channel;
    logic [LEVEL_IN_W-1:0] current_level;
    logic [LEVEL_IN_W-1:0] target_level;
    logic [SECS_W-1:0]     fade_seconds;
  } dcf_in_t;

  typedef struct packed {
    logic [CH_W-1:0]       out_channel;
    logic [LEVEL_IN_W-1:0] level;
    logic                  last;
  } dcf_out_t;

  typedef struct packed {
    logic              start;
    logic [QUOT_W-1:0] dividend;
    logic [DIVR_W-1:0] divisor;
  } dcf_div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quotient;
  } dcf_div_rsp_t;

  typedef struct packed {
    logic             en;
    logic [CH_W-1:0]  addr;
    logic [MEM_W-1:0] data;
  } dcf_mem_wr_t;

endpackage
`default_nettype wire

>>> sv/dmx_channel_crossfade_top.sv
// Load word: busy through the divider (24 divider steps, plus setup and write-back),
//   or only for the write-back when the fade length is zero; produces no result.
// Tick word: one result per channel in use (memory read, then add/clamp/write),
//   walking channels 0 to N-1 for N channels; no result when N is zero.
// Results are strobed for one cycle on out_valid; the receiver cannot stall.
// Synchronous active-low reset: all levels and steps read as zero, 60 channels.
`default_nettype none
module dmx_channel_crossfade_top
  import dcf_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire dcf_in_t          in_word,
  output logic                  out_valid,
  output dcf_out_t              out_word,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_wdata
);

  dcf_state_t state_r, state_nxt;

  logic [CFG_W-1:0]      cfg_r;
  logic [CFG_W-1:0]      n_r, n_nxt;
  logic [CH_W-1:0]       idx_r, idx_nxt;
  logic [CH_W-1:0]       ch_r, ch_nxt;
  logic [LEVEL_IN_W-1:0] cur_r, cur_nxt;
  logic                  neg_r, neg_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;
  logic                  out_valid_r, out_valid_nxt;
  dcf_out_t              out_word_r, out_word_nxt;

  logic                  accept;
  logic [CFG_W-1:0]      n_sat;
  logic [LEVEL_IN_W-1:0] mag;
  logic                  last_ch;

  dcf_div_req_t div_req;
  dcf_div_rsp_t div_rsp;
  dcf_mem_wr_t  mem_wr;
  logic         mem_rd_en;
  logic [MEM_W-1:0] mem_rd_data;

  logic [LEVEL_W-1:0] lvl_old;
  logic [STEP_W-1:0]  lvl_step;
  logic [SUM_W-1:0]   sum;
  logic [LEVEL_W-1:0] lvl_new;

  dcf_divider u_div (
    .clk (clk),
    .rst_n (rst_n),
    .req (div_req),
    .rsp (div_rsp)
  );

  dcf_level_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (mem_wr),
    .rd_en   (mem_rd_en),
    .rd_addr (idx_r),
    .rd_data (mem_rd_data)
  );

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // Saturate the channel count to the store size
  assign n_sat   = (cfg_r > CFG_MAX) ? CFG_MAX : cfg_r;
  assign mag     = (in_word.target_level >= in_word.current_level) ?
                   in_word.target_level - in_word.current_level :
                   in_word.current_level - in_word.target_level;
  assign last_ch = (({1'b0, idx_r} + CFG_W'(1)) == n_r);

  // Add the step and clamp to 0 .. 255.0
  always_comb begin
    lvl_old  = mem_rd_data[MEM_W-1 -: LEVEL_W];
    lvl_step = mem_rd_data[STEP_W-1:0];
    sum      = {2'b00, lvl_old} + {lvl_step[STEP_W-1], lvl_step};
    if (sum[SUM_W-1]) begin
      lvl_new = '0;
    end else if (sum[STEP_W-1:0] > LEVEL_MAX_Q) begin
      lvl_new = LEVEL_W'(LEVEL_MAX_Q);
    end else begin
      lvl_new = sum[LEVEL_W-1:0];
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_word.func == FUNC_TICK) begin
            state_nxt = (n_sat == '0) ? ST_IDLE : ST_TICK_RD;
          end else if (in_word.fade_seconds == '0) begin
            state_nxt = ST_LOAD_WR;
          end else begin
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV:     state_nxt = div_rsp.done ? ST_LOAD_WR : ST_DIV;
      ST_LOAD_WR: state_nxt = ST_IDLE;
      ST_TICK_RD: state_nxt = ST_TICK_WB;
      ST_TICK_WB: state_nxt = last_ch ? ST_IDLE : ST_TICK_RD;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs: divider start, memory ports, result strobe
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = {mag, FRAC_W'(0)};
    div_req.divisor  = DIVR_W'({7'd0, in_word.fade_seconds} * DIVR_W'(TICKS_PER_SEC));
    mem_wr.en        = 1'b0;
    mem_wr.addr      = ch_r;
    mem_wr.data      = {cur_r, FRAC_W'(0), step_r};
    mem_rd_en        = 1'b0;
    out_valid_nxt    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        div_req.start = accept && (in_word.func == FUNC_LOAD) &&
                        (in_word.fade_seconds != '0);
      end
      ST_LOAD_WR: begin
        mem_wr.en = 1'b1;
      end
      ST_TICK_RD: begin
        mem_rd_en = 1'b1;
      end
      ST_TICK_WB: begin
        mem_wr.en     = 1'b1;
        mem_wr.addr   = idx_r;
        mem_wr.data   = {lvl_new, lvl_step};
        out_valid_nxt = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Datapath registers
  always_comb begin
    n_nxt        = n_r;
    idx_nxt      = idx_r;
    ch_nxt       = ch_r;
    cur_nxt      = cur_r;
    neg_nxt      = neg_r;
    step_nxt     = step_r;
    out_word_nxt = out_word_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          n_nxt    = n_sat;
          idx_nxt  = '0;
          ch_nxt   = in_word.channel;
          cur_nxt  = in_word.current_level;
          neg_nxt  = (in_word.target_level < in_word.current_level);
          step_nxt = '0;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          step_nxt = neg_r ? STEP_W'(-{1'b0, div_rsp.quotient}) :
                             STEP_W'({1'b0, div_rsp.quotient});
        end
      end
      ST_TICK_WB: begin
        out_word_nxt.out_channel = idx_r;
        out_word_nxt.level       = lvl_new[LEVEL_W-1 -: LEVEL_IN_W];
        out_word_nxt.last        = last_ch;
        idx_nxt                  = idx_r + CH_W'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cfg_r       <= CFG_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
    end
    n_r        <= n_nxt;
    idx_r      <= idx_nxt;
    ch_r       <= ch_nxt;
    cur_r      <= cur_nxt;
    neg_r      <= neg_nxt;
    step_r     <= step_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // The last word of a tick coincides with the return to idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.last |-> !busy)
    else $error("last word shown while walk still running");

  // Channel words are spaced by the read cycle
  a_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.last |=> !out_valid)
    else $error("back-to-back result words");

  // Reported channel lies within the walked range
  a_ch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, out_word.out_channel} < n_r))
    else $error("reported channel beyond channels in use");

  // Words in a walk come in ascending channel order
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.last |=> ##1
      (out_valid && out_word.out_channel == $past(out_word.out_channel, 2) + CH_W'(1)))
    else $error("channel walk out of order");

endmodule
`default_nettype wire

>>> sv/dcf_divider.sv
`default_nettype none
module dcf_divider
  import dcf_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire dcf_div_req_t req,
  output dcf_div_rsp_t      rsp
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DCNT_W-1:0] count_r, count_nxt;
  logic [DIVR_W-1:0] rem_r, rem_nxt;
  logic [QUOT_W-1:0] quo_r, quo_nxt;
  logic [DIVR_W-1:0] divisor_r, divisor_nxt;

  logic [DIVR_W:0]   rem_sh;
  logic              ge;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    rem_sh = {rem_r, quo_r[QUOT_W-1]};
    ge     = (rem_sh >= {1'b0, divisor_r});
  end

  always_comb begin
    busy_nxt    = busy_r;
    done_nxt    = 1'b0;
    count_nxt   = count_r;
    rem_nxt     = rem_r;
    quo_nxt     = quo_r;
    divisor_nxt = divisor_r;
    if (req.start) begin
      busy_nxt    = 1'b1;
      count_nxt   = '0;
      rem_nxt     = '0;
      quo_nxt     = req.dividend;
      divisor_nxt = req.divisor;
    end else if (busy_r) begin
      rem_nxt   = ge ? DIVR_W'(rem_sh - {1'b0, divisor_r}) : DIVR_W'(rem_sh);
      quo_nxt   = {quo_r[QUOT_W-2:0], ge};
      count_nxt = count_r + DCNT_W'(1);
      if (count_r == DCNT_W'(QUOT_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      count_r <= '0;
    end else begin
      busy_r  <= busy_nxt;
      done_r  <= done_nxt;
      count_r <= count_nxt;
    end
    rem_r     <= rem_nxt;
    quo_r     <= quo_nxt;
    divisor_r <= divisor_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

  // A finished division leaves the unit idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("divider done while still stepping");

  // Remainder stays below the divisor during stepping
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !$past(req.start) |-> rem_r < divisor_r || divisor_r == '0)
    else $error("divider remainder out of range");

  // A start is only issued to an idle unit
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("divider started while busy");

endmodule
`default_nettype wire

>>> sv/dcf_level_mem.sv
`default_nettype none
module dcf_level_mem
  import dcf_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire dcf_mem_wr_t      wr,
  input  wire logic             rd_en,
  input  wire logic [CH_W-1:0]  rd_addr,
  output logic      [MEM_W-1:0] rd_data
);

  logic [MEM_W-1:0]        mem [MAX_CHANNELS];
  logic [MAX_CHANNELS-1:0] valid_r;
  logic [MEM_W-1:0]        rd_data_r;
  logic                    rd_valid_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Mark written entries; reset clears the whole row of flags at once
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.en) begin
      valid_r[wr.addr] <= 1'b1;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r  <= mem[rd_addr];
      rd_valid_r <= valid_r[rd_addr];
    end
  end

  // Entries never written read as zero level, zero step
  assign rd_data = rd_valid_r ? rd_data_r : '0;

endmodule
`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 100ps
module testbench;
  import dcf_pkg::*;

  localparam int SETTLE_CYCLES = 30;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam logic signed [SUM_W-1:0] FULL_SCALE_Q = 26'sh0FF0000;

  logic clk;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  dcf_in_t in_word = '0;
  logic out_valid;
  dcf_out_t out_word;
  logic cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  // Mirror of the channel store and the channel count
  logic [LEVEL_W-1:0] level_q[MAX_CHANNELS];
  logic signed [STEP_W-1:0] step_q[MAX_CHANNELS];
  logic [CFG_W-1:0] chans_in_use;
  dcf_out_t pending_levels[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit gaps_on = 1'b1;

  dmx_channel_crossfade_top DUT (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_word(in_word),
    .out_valid(out_valid),
    .out_word(out_word),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Signed Q9.16 step: level difference over the tick count, truncated toward zero
  function automatic logic signed [STEP_W-1:0] fade_step_q(logic [7:0] cur, logic [7:0] tgt,
                                                           logic [7:0] secs);
    logic [7:0] mag;
    logic [QUOT_W-1:0] mag_q;
    logic [DIVR_W-1:0] ticks;
    logic [QUOT_W-1:0] quot;
    if (secs == 0) return '0;
    ticks = DIVR_W'(secs * TICKS_PER_SEC);
    mag = (tgt >= cur) ? tgt - cur : cur - tgt;
    mag_q = {mag, 16'h0000};
    quot = mag_q / ticks;
    return (tgt >= cur) ? $signed({1'b0, quot}) : -$signed({1'b0, quot});
  endfunction

  // Advance every channel in use by its step, clamp, and queue its level
  task automatic predict_tick();
    int n;
    logic signed [SUM_W-1:0] sum;
    dcf_out_t res;
    n = (chans_in_use > MAX_CHANNELS) ? MAX_CHANNELS : int'(chans_in_use);
    for (int i = 0; i < n; i++) begin
      sum = $signed({2'b00, level_q[i]}) + step_q[i];
      if (sum < 0) sum = '0;
      else if (sum > FULL_SCALE_Q) sum = FULL_SCALE_Q;
      level_q[i] = sum[LEVEL_W-1:0];
      res.out_channel = i[CH_W-1:0];
      res.level = sum[LEVEL_W-1:FRAC_W];
      res.last = (i == n - 1);
      pending_levels.push_back(res);
    end
  endtask

  task automatic predict_word(dcf_in_t w);
    if (w.func == FUNC_TICK) begin
      predict_tick();
    end else begin
      level_q[w.channel] = {w.current_level, 16'h0000};
      step_q[w.channel] = fade_step_q(w.current_level, w.target_level, w.fade_seconds);
    end
  endtask

  // Send one word, after a random gap if gaps are on; start stays high on return
  task automatic send_word(dcf_in_t w);
    int gap;
    gap = gaps_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy);
    predict_word(w);
  endtask

  // Drop start, drain all expected levels, then let a load finish
  task automatic settle();
    start <= 1'b0;
    while (pending_levels.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_chan_count(logic [CFG_W-1:0] value);
    settle();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    chans_in_use = value;
  endtask

  function automatic dcf_in_t load_word(logic [5:0] ch, logic [7:0] cur, logic [7:0] tgt,
                                        logic [7:0] secs);
    dcf_in_t w;
    w.func = FUNC_LOAD;
    w.channel = ch;
    w.current_level = cur;
    w.target_level = tgt;
    w.fade_seconds = secs;
    return w;
  endfunction

  // Tick with random content in the fields a tick ignores
  function automatic dcf_in_t tick_word();
    dcf_in_t w;
    w = dcf_in_t'($urandom());
    w.func = FUNC_TICK;
    return w;
  endfunction

  // Compare each strobed level with the oldest expectation
  always @(posedge clk) begin
    dcf_out_t exp_w;
    if (rst_n && out_valid) begin
      if (pending_levels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: ch %0d level %0d last %0b",
                   out_word.out_channel, out_word.level, out_word.last);
      end else begin
        exp_w = pending_levels.pop_front();
        if (out_word.out_channel !== exp_w.out_channel || out_word.level !== exp_w.level ||
            out_word.last !== exp_w.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected ch %0d level %0d last %0b, got ch %0d level %0d last %0b",
                     exp_w.out_channel, exp_w.level, exp_w.last,
                     out_word.out_channel, out_word.level, out_word.last);
        end
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Tick from reset: all channels read zero, ignored fields all ones
  task automatic test_reset_tick();
    dcf_in_t w;
    w = '1;
    w.func = FUNC_TICK;
    send_word(w);
  endtask

  // Loads at the field extremes, zero difference, zero fade, falling fade, then ticks over 64 channels
  task automatic test_loads();
    send_word(load_word(6'd0, 8'd0, 8'd255, 8'd1));
    send_word(load_word(6'd63, 8'd255, 8'd0, 8'd255));
    send_word(load_word(6'd1, 8'd128, 8'd128, 8'd10));
    send_word(load_word(6'd2, 8'd77, 8'd200, 8'd0));
    send_word(load_word(6'd3, 8'd200, 8'd3, 8'd7));
    write_chan_count(7'd64);
    send_word(tick_word());
    send_word('{func: FUNC_TICK, default: '0});
  endtask

  // Saturating, empty and single-channel counts
  task automatic test_chan_count_extremes();
    write_chan_count(7'd127);
    send_word(tick_word());
    write_chan_count(7'd0);
    send_word(tick_word());
    send_word(tick_word());
    write_chan_count(7'd1);
    send_word(tick_word());
  endtask

  // One-second fades run past their end so both clamps are hit
  task automatic test_fades_to_clamp();
    int n;
    n = $urandom_range(2, 4);
    write_chan_count(n[CFG_W-1:0]);
    gaps_on = 1'b0;
    send_word(load_word(6'd0, 8'($urandom_range(0, 255)), 8'd255, 8'd1));
    send_word(load_word(6'd1, 8'($urandom_range(0, 255)), 8'd0, 8'd1));
    for (int ch = 2; ch < n; ch++)
      send_word(load_word(ch[5:0], 8'($urandom()),
                          ($urandom_range(0, 1) ? 8'd250 : 8'd5), 8'd1));
    send_word(load_word(6'($urandom_range(n, 63)), 8'($urandom()), 8'($urandom()),
                        8'($urandom())));
    for (int i = 0; i < 103; i++) begin
      gaps_on = (i >= 50);
      send_word(tick_word());
    end
  endtask

  // Random loads and ticks over several channel counts
  task automatic test_random_mix();
    dcf_in_t w;
    logic [CFG_W-1:0] counts[3];
    counts[0] = CFG_W'($urandom_range(1, 8));
    counts[1] = 7'd64;
    counts[2] = CFG_W'($urandom_range(0, 127));
    for (int ph = 0; ph < 3; ph++) begin
      write_chan_count(counts[ph]);
      gaps_on = (ph != 1);
      for (int i = 0; i < 4; i++) begin
        if ($urandom_range(0, 99) < 35) begin
          w = dcf_in_t'($urandom());
          w.func = FUNC_LOAD;
          if ($urandom_range(0, 1)) w.fade_seconds = SECS_W'($urandom_range(0, 3));
        end else begin
          w = tick_word();
        end
        send_word(w);
      end
    end
  endtask

  initial begin
    for (int i = 0; i < MAX_CHANNELS; i++) begin
      level_q[i] = '0;
      step_q[i] = '0;
    end
    chans_in_use = CFG_RESET;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_tick();
    test_loads();
    test_chan_count_extremes();
    test_fades_to_clamp();
    test_random_mix();

    settle();
    if (mismatches == 0 && pending_levels.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> dmx_channel_crossfade_top.f
sv/dcf_pkg.sv
sv/dcf_divider.sv
sv/dcf_level_mem.sv
sv/dmx_channel_crossfade_top.sv
tb/testbench.sv
